@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker of the heartbeat monitor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge and muted during reset.
`define HBNM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same-cycle implication.
`define HBNM_ASSERT_SAME(label, ante, cons, msg) \
  `HBNM_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define HBNM_ASSERT_NEXT(label, ante, cons, msg) \
  `HBNM_ASSERT(label, (ante) |=> (cons), msg)

`endif

@@ hw/rtl/hbnm_pkg.sv @@
// Types, codes and constants shared by the heartbeat node monitor modules.
package hbnm_pkg;

  localparam int unsigned MAX_NODES_DEFAULT = 16;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned TMO_W   = 16;

  localparam logic [PADDR_W-3:0] REG_DEFAULT_TIMEOUT = '0;
  localparam logic [TMO_W-1:0]   DEFAULT_TIMEOUT_RESET = 16'd3000;

  // Command codes of an input word.
  localparam logic [2:0] CMD_REGISTER  = 3'd0;
  localparam logic [2:0] CMD_BOOTUP    = 3'd1;
  localparam logic [2:0] CMD_HEARTBEAT = 3'd2;
  localparam logic [2:0] CMD_CAPS      = 3'd3;
  localparam logic [2:0] CMD_TICK      = 3'd4;

  // Result kinds.
  localparam logic [1:0] KIND_DONE   = 2'd0;
  localparam logic [1:0] KIND_NOTICE = 2'd1;
  localparam logic [1:0] KIND_START  = 2'd2;
  localparam logic [1:0] KIND_FULL   = 2'd3;

  // Decoded node states.
  localparam logic [2:0] ST_UNKNOWN = 3'd0;
  localparam logic [2:0] ST_PREOP   = 3'd1;
  localparam logic [2:0] ST_OPER    = 3'd2;
  localparam logic [2:0] ST_STOPPED = 3'd3;
  localparam logic [2:0] ST_OFFLINE = 3'd4;

  // Raw heartbeat state bytes.
  localparam logic [7:0] HB_PREOP   = 8'h7F;
  localparam logic [7:0] HB_OPER    = 8'h05;
  localparam logic [7:0] HB_STOPPED = 8'h04;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [6:0]       node_id;
    logic [7:0]       state_byte;
    logic [7:0]       caps;
    logic [TMO_W-1:0] timeout_ms;
    logic [31:0]      now_ms;
  } in_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [6:0] out_node;
    logic [2:0] node_state;
    logic       is_online;
    logic       last_of_run;
  } out_t;

  typedef struct packed {
    logic [6:0]       id;
    logic [2:0]       state;
    logic [7:0]       caps;
    logic [31:0]      last_seen;
    logic [TMO_W-1:0] timeout;
    logic             online;
  } entry_t;

  // Which result the datapath loads into the output register.
  typedef enum logic [2:0] {
    RES_FIRST,
    RES_FINAL,
    RES_FULL,
    RES_BAD,
    RES_TICK_DONE,
    RES_SCAN
  } res_sel_e;

  typedef struct packed {
    logic     in_load;
    logic     idx_clr;
    logic     idx_inc;
    logic     rd_en;
    logic     cur_load_rd;
    logic     cur_load_new;
    logic     cnt_inc;
    logic     wr_en;
    logic     out_load;
    res_sel_e out_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic is_table;
    logic at_end;
    logic full;
    logic match;
    logic expired;
    logic need_first;
  } dp_status_t;

  function automatic logic [2:0] decode_hb(input logic [7:0] sb);
    logic [2:0] st;
    case (sb)
      HB_PREOP:   st = ST_PREOP;
      HB_OPER:    st = ST_OPER;
      HB_STOPPED: st = ST_STOPPED;
      default:    st = ST_UNKNOWN;
    endcase
    return st;
  endfunction

endpackage

@@ hw/rtl/hbnm_ctrl.sv @@
// Sequencer of the heartbeat node monitor: table search, update, scan and result hand-off.
module hbnm_ctrl
  import hbnm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    IDLE,
    DISPATCH,
    FIND_RD,
    FIND_CMP,
    UPDATE,
    EMIT_A,
    EMIT_B,
    SCAN_RD,
    SCAN_CMP,
    SCAN_EMIT
  } state_e;

  state_e   state_q, state_d;
  res_sel_e fin_sel_q, fin_sel_d;
  logic     out_valid_q, out_valid_d;
  logic     can_emit;

  assign in_ready_o  = (state_q == IDLE);
  assign out_valid_o = out_valid_q;
  assign can_emit    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    fin_sel_d = fin_sel_q;
    cmd_o     = '0;
    cmd_o.out_sel = RES_FINAL;

    unique case (state_q)
      IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d       = DISPATCH;
        end
      end
      DISPATCH: begin
        if (status_i.is_tick) begin
          state_d = SCAN_RD;
        end else if (status_i.is_table) begin
          state_d = FIND_RD;
        end else begin
          fin_sel_d = RES_BAD;
          state_d   = EMIT_B;
        end
      end
      FIND_RD: begin
        if (status_i.at_end) begin
          if (status_i.full) begin
            fin_sel_d = RES_FULL;
            state_d   = EMIT_B;
          end else begin
            cmd_o.cur_load_new = 1'b1;
            cmd_o.cnt_inc      = 1'b1;
            state_d            = UPDATE;
          end
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = FIND_CMP;
        end
      end
      FIND_CMP: begin
        if (status_i.match) begin
          cmd_o.cur_load_rd = 1'b1;
          state_d           = UPDATE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = FIND_RD;
        end
      end
      UPDATE: begin
        cmd_o.wr_en = 1'b1;
        fin_sel_d   = RES_FINAL;
        state_d     = status_i.need_first ? EMIT_A : EMIT_B;
      end
      EMIT_A: begin
        cmd_o.out_sel = RES_FIRST;
        if (can_emit) begin
          cmd_o.out_load = 1'b1;
          state_d        = EMIT_B;
        end
      end
      EMIT_B: begin
        cmd_o.out_sel = fin_sel_q;
        if (can_emit) begin
          cmd_o.out_load = 1'b1;
          state_d        = IDLE;
        end
      end
      SCAN_RD: begin
        if (status_i.at_end) begin
          fin_sel_d = RES_TICK_DONE;
          state_d   = EMIT_B;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = SCAN_CMP;
        end
      end
      SCAN_CMP: begin
        cmd_o.cur_load_rd = 1'b1;
        if (status_i.expired) begin
          state_d = SCAN_EMIT;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = SCAN_RD;
        end
      end
      SCAN_EMIT: begin
        cmd_o.out_sel = RES_SCAN;
        if (can_emit) begin
          cmd_o.wr_en    = 1'b1;
          cmd_o.out_load = 1'b1;
          cmd_o.idx_inc  = 1'b1;
          state_d        = SCAN_RD;
        end
      end
      default: state_d = IDLE;
    endcase

    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      fin_sel_q   <= RES_FINAL;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fin_sel_q   <= fin_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hw/rtl/hbnm_datapath.sv @@
// Node table memory, entry update logic and output word register of the monitor.
module hbnm_datapath
  import hbnm_pkg::*;
#(
  parameter int unsigned MAX_NODES = MAX_NODES_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_cmd_t        cmd_i,
  output dp_status_t       status_o,
  input  in_t              in_data_i,
  input  logic [TMO_W-1:0] dflt_timeout_i,
  output out_t             out_data_o
);

  localparam int unsigned IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);

  entry_t           mem [MAX_NODES];
  in_t              in_q;
  entry_t           rd_q;
  entry_t           cur_q;
  out_t             out_q;
  logic [CNT_W-1:0] idx_q;
  logic [CNT_W-1:0] count_q;

  entry_t     new_entry;
  entry_t     wr_data;
  out_t       final_res;
  out_t       out_d;
  logic [2:0] hb_state;
  logic [31:0] elapsed;

  assign hb_state = decode_hb(in_q.state_byte);
  assign elapsed  = in_q.now_ms - rd_q.last_seen;

  always_comb begin
    new_entry           = '0;
    new_entry.id        = in_q.node_id;
    new_entry.state     = ST_UNKNOWN;
    new_entry.last_seen = in_q.now_ms;
    new_entry.timeout   = dflt_timeout_i;
  end

  // Updated entry and final result for the command in hand.
  always_comb begin
    wr_data   = cur_q;
    final_res = '{result_kind: KIND_DONE, out_node: in_q.node_id,
                  node_state: cur_q.state, is_online: cur_q.online, last_of_run: 1'b1};
    case (in_q.cmd)
      CMD_REGISTER: wr_data.timeout = in_q.timeout_ms;
      CMD_CAPS:     wr_data.caps    = in_q.caps;
      CMD_BOOTUP: begin
        wr_data.state         = ST_PREOP;
        wr_data.online        = 1'b1;
        wr_data.last_seen     = in_q.now_ms;
        final_res.result_kind = KIND_START;
        final_res.node_state  = ST_PREOP;
        final_res.is_online   = 1'b1;
      end
      CMD_HEARTBEAT: begin
        wr_data.state        = hb_state;
        wr_data.online       = 1'b1;
        wr_data.last_seen    = in_q.now_ms;
        final_res.node_state = hb_state;
        final_res.is_online  = 1'b1;
        if (!cur_q.online || (cur_q.state != hb_state)) begin
          final_res.result_kind = KIND_NOTICE;
        end
      end
      default: begin
        // Timeout scan: the entry goes offline.
        wr_data.state  = ST_OFFLINE;
        wr_data.online = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_d = '0;
    case (cmd_i.out_sel)
      RES_FIRST: out_d = '{result_kind: KIND_NOTICE, out_node: in_q.node_id,
                           node_state: ST_PREOP, is_online: 1'b1, last_of_run: 1'b0};
      RES_FINAL: out_d = final_res;
      RES_FULL:  out_d = '{result_kind: KIND_FULL, out_node: in_q.node_id,
                           node_state: ST_UNKNOWN, is_online: 1'b0, last_of_run: 1'b1};
      RES_BAD:   out_d = '{result_kind: KIND_DONE, out_node: in_q.node_id,
                           node_state: ST_UNKNOWN, is_online: 1'b0, last_of_run: 1'b1};
      RES_SCAN:  out_d = '{result_kind: KIND_NOTICE, out_node: cur_q.id,
                           node_state: ST_OFFLINE, is_online: 1'b0, last_of_run: 1'b0};
      default:   out_d = '{result_kind: KIND_DONE, out_node: '0,
                           node_state: ST_UNKNOWN, is_online: 1'b0, last_of_run: 1'b1};
    endcase
  end

  always_comb begin
    status_o.is_tick    = (in_q.cmd == CMD_TICK);
    status_o.is_table   = (in_q.cmd < CMD_TICK);
    status_o.at_end     = (idx_q == count_q);
    status_o.full       = (count_q == CNT_W'(MAX_NODES));
    status_o.match      = (rd_q.id == in_q.node_id);
    status_o.expired    = rd_q.online && (elapsed > {16'd0, rd_q.timeout});
    status_o.need_first = (in_q.cmd == CMD_BOOTUP) && !cur_q.online;
  end

  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      count_q <= '0;
    end else begin
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      in_q <= in_data_i;
    end
    if (cmd_i.cur_load_rd) begin
      cur_q <= rd_q;
    end else if (cmd_i.cur_load_new) begin
      cur_q <= new_entry;
    end
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  // Node table: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[idx_q[IDX_W-1:0]] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[idx_q[IDX_W-1:0]];
    end
  end

endmodule

@@ hw/rtl/heartbeat_node_monitor_top.sv @@
// A node event looks up its id, adds an entry when it is absent and the table has room, writes
// the entry back and gives its results. A tick reads each entry, gives an offline notice per
// expired one, then the done word. Throughput: one event word at a time, limited by the single
// table read port the walk uses; the next word is accepted once the final result of the current
// one sits in the output register. Reset clears the entry count, the sequencer and the output
// valid, sets the default timeout to 3000 ms and leaves the table contents as they are.
module heartbeat_node_monitor_top
  import hbnm_pkg::*;
#(
  parameter int unsigned MAX_NODES = MAX_NODES_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Event words in.
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  // Result words out.
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o,
  // Register port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // The register block holds the single configuration register, the timeout
  // that newly added table entries start with. Low address bits select a
  // byte within the word and are ignored.
  logic [TMO_W-1:0] dflt_timeout_q, dflt_timeout_d;
  logic             reg_hit;
  logic             reg_write;

  assign pready    = 1'b1;
  assign reg_hit   = (paddr[PADDR_W-1:2] == REG_DEFAULT_TIMEOUT);
  assign reg_write = psel && penable && pwrite && pready && reg_hit;
  assign prdata    = reg_hit ? {{(PDATA_W - TMO_W){1'b0}}, dflt_timeout_q} : '0;

  always_comb begin
    dflt_timeout_d = dflt_timeout_q;
    if (reg_write) begin
      dflt_timeout_d = pwdata[TMO_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_timeout_q <= DEFAULT_TIMEOUT_RESET;
    end else begin
      dflt_timeout_q <= dflt_timeout_d;
    end
  end

  // The sequencer walks the table through the datapath one entry at a time.
  // For node events it searches for the node id, appends a new entry when
  // the id is absent and the table has room, then writes back the updated
  // entry and hands out one or two result words. For a tick it visits every
  // entry below the count and writes back each one that timed out.
  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  hbnm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (ctrl_cmd)
  );

  hbnm_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctrl_cmd),
    .status_o       (dp_status),
    .in_data_i      (in_data_i),
    .dflt_timeout_i (dflt_timeout_q),
    .out_data_o     (out_data_o)
  );

endmodule

@@ hw/rtl/hbnm_checker.sv @@
// Port-level checks of the heartbeat node monitor and their binding to the top level.
`include "assert_macros.svh"

module hbnm_checker
  import hbnm_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // A stalled result word stays offered and unchanged.
  `HBNM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result word dropped")
  `HBNM_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_data_o), "result word changed")

  // One event word is worked on at a time.
  `HBNM_ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o, "word taken while busy")

  // A full-table word closes its run and carries no state.
  `HBNM_ASSERT_SAME(a_full_word, out_valid_o && (out_data_o.result_kind == KIND_FULL), (out_data_o.node_state == ST_UNKNOWN) && !out_data_o.is_online && out_data_o.last_of_run, "bad table-full word")

  // An offline notice is never the last word of a run and shows the node offline.
  `HBNM_ASSERT_SAME(a_offline_word, out_valid_o && (out_data_o.result_kind == KIND_NOTICE) && (out_data_o.node_state == ST_OFFLINE), !out_data_o.is_online && !out_data_o.last_of_run, "bad offline notice")

endmodule

bind heartbeat_node_monitor_top hbnm_checker u_checker (.*);

@@ dv/testbench.sv @@
// Self-checking testbench for the heartbeat node monitor: random and directed event words.
module testbench;
  import hbnm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The table depth matches the default parameter of the instance below.
  localparam int unsigned TABLE_DEPTH = MAX_NODES_DEFAULT;

  // Command codes five to seven are not decoded; the block answers them with a done word.
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

  // The default timeout register is register zero, at byte address zero.
  localparam logic [PADDR_W-1:0] DEFAULT_TIMEOUT_ADDR = {REG_DEFAULT_TIMEOUT, 2'b00};

  // A tick walks the whole table, and the receiver may stall each result for a while.
  // The limit below counts the cycles of the whole run.
  localparam int unsigned CYCLE_LIMIT = 1000000;

  // Number of cycles the receiver holds off once, so that the block backs up.
  localparam int unsigned HOLD_OFF_CYCLES = 400;

  // Cycles waited after the last expected word, to catch anything extra.
  localparam int unsigned TAIL_CYCLES = 60;

  // Mirror of the node table, the default timeout and the words still awaited.
  class node_watch_scoreboard;
    logic [6:0]       node_ids     [TABLE_DEPTH];
    logic [2:0]       node_states  [TABLE_DEPTH];
    logic [7:0]       cap_bytes    [TABLE_DEPTH];
    logic [31:0]      seen_ms      [TABLE_DEPTH];
    logic [TMO_W-1:0] node_timeout [TABLE_DEPTH];
    logic             online       [TABLE_DEPTH];
    int unsigned      entry_count  = 0;
    logic [TMO_W-1:0] default_tmo  = DEFAULT_TIMEOUT_RESET;
    out_t             awaited_results[$];
    int unsigned      mismatches   = 0;

    function out_t result_word(input logic [1:0] kind, input logic [6:0] node,
                               input logic [2:0] st, input logic on);
      out_t r;
      r.result_kind = kind;
      r.out_node    = node;
      r.node_state  = st;
      r.is_online   = on;
      r.last_of_run = 1'b0;
      return r;
    endfunction

    // Works out every word that one accepted event causes and queues them in order.
    function void note_event(input in_t w);
      int         slot;
      int unsigned first;
      logic       was_on;
      logic [2:0] prior;
      logic [2:0] decoded;
      out_t       tail;
      slot  = -1;
      first = awaited_results.size();
      if (w.cmd == CMD_TICK) begin
        // Elapsed time is taken modulo 2^32, so a wrapped clock still works.
        for (int i = 0; i < int'(entry_count); i++) begin
          if (online[i] && (w.now_ms - seen_ms[i]) > 32'(node_timeout[i])) begin
            online[i]      = 1'b0;
            node_states[i] = ST_OFFLINE;
            awaited_results.push_back(result_word(KIND_NOTICE, node_ids[i], ST_OFFLINE, 1'b0));
          end
        end
        awaited_results.push_back(result_word(KIND_DONE, '0, ST_UNKNOWN, 1'b0));
      end else if (w.cmd <= CMD_CAPS) begin
        for (int i = 0; i < int'(entry_count); i++) begin
          if (node_ids[i] == w.node_id) slot = i;
        end
        if (slot < 0 && entry_count < TABLE_DEPTH) begin
          slot               = entry_count;
          entry_count++;
          node_ids[slot]     = w.node_id;
          node_states[slot]  = ST_UNKNOWN;
          cap_bytes[slot]    = '0;
          seen_ms[slot]      = w.now_ms;
          node_timeout[slot] = default_tmo;
          online[slot]       = 1'b0;
        end
        if (slot < 0) begin
          awaited_results.push_back(result_word(KIND_FULL, w.node_id, ST_UNKNOWN, 1'b0));
        end else begin
          case (w.cmd)
            CMD_REGISTER: begin
              node_timeout[slot] = w.timeout_ms;
              awaited_results.push_back(result_word(KIND_DONE, w.node_id, node_states[slot],
                                                    online[slot]));
            end
            CMD_CAPS: begin
              cap_bytes[slot] = w.caps;
              awaited_results.push_back(result_word(KIND_DONE, w.node_id, node_states[slot],
                                                    online[slot]));
            end
            CMD_BOOTUP: begin
              was_on            = online[slot];
              node_states[slot] = ST_PREOP;
              online[slot]      = 1'b1;
              seen_ms[slot]     = w.now_ms;
              if (!was_on) begin
                awaited_results.push_back(result_word(KIND_NOTICE, w.node_id, ST_PREOP, 1'b1));
              end
              awaited_results.push_back(result_word(KIND_START, w.node_id, ST_PREOP, 1'b1));
            end
            default: begin
              was_on = online[slot];
              prior  = node_states[slot];
              case (w.state_byte)
                HB_PREOP:   decoded = ST_PREOP;
                HB_OPER:    decoded = ST_OPER;
                HB_STOPPED: decoded = ST_STOPPED;
                default:    decoded = ST_UNKNOWN;
              endcase
              node_states[slot] = decoded;
              online[slot]      = 1'b1;
              seen_ms[slot]     = w.now_ms;
              awaited_results.push_back(result_word((!was_on || prior != decoded) ?
                                                    KIND_NOTICE : KIND_DONE,
                                                    w.node_id, decoded, 1'b1));
            end
          endcase
        end
      end else begin
        awaited_results.push_back(result_word(KIND_DONE, w.node_id, ST_UNKNOWN, 1'b0));
      end
      // The final word of this event carries the end-of-run flag.
      if (awaited_results.size() > first) begin
        tail = awaited_results.pop_back();
        tail.last_of_run = 1'b1;
        awaited_results.push_back(tail);
      end
    endfunction

    function void flag(input string what, input out_t want, input out_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t %s: expected kind=%0d node=%h state=%0d online=%b last=%b, got kind=%0d node=%h state=%0d online=%b last=%b",
                 $realtime, what, want.result_kind, want.out_node, want.node_state,
                 want.is_online, want.last_of_run, got.result_kind, got.out_node,
                 got.node_state, got.is_online, got.last_of_run);
      end
    endfunction

    // Compares one delivered word, field by field, with the oldest awaited one.
    function void check_result(input out_t got);
      out_t want;
      if (awaited_results.size() == 0) begin
        flag("unexpected word", '0, got);
        return;
      end
      want = awaited_results.pop_front();
      if (got.result_kind !== want.result_kind || got.out_node !== want.out_node ||
          got.node_state !== want.node_state || got.is_online !== want.is_online ||
          got.last_of_run !== want.last_of_run) begin
        flag("word mismatch", want, got);
      end
    endfunction

    function void check_register(input logic [PDATA_W-1:0] got);
      if (got !== PDATA_W'(default_tmo)) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t default timeout readback: expected %h, got %h",
                   $realtime, PDATA_W'(default_tmo), got);
        end
      end
    endfunction
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_ready_o;
  in_t                in_data     = '0;
  logic               out_valid_o;
  logic               out_ready   = 1'b0;
  out_t               out_data_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [PDATA_W-1:0] pwdata      = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  node_watch_scoreboard sb = new;

  // While steady is set, neither side inserts idle cycles.
  bit                 steady      = 1'b0;
  int unsigned        cycle_count = 0;
  logic [31:0]        clock_ms    = '0;
  logic [6:0]         node_pool [TABLE_DEPTH];

  heartbeat_node_monitor_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic in_t event_word(input logic [2:0] cmd, input logic [6:0] node,
                                     input logic [7:0] sbyte, input logic [7:0] caps,
                                     input logic [TMO_W-1:0] tmo, input logic [31:0] now);
    in_t w;
    w.cmd        = cmd;
    w.node_id    = node;
    w.state_byte = sbyte;
    w.caps       = caps;
    w.timeout_ms = tmo;
    w.now_ms     = now;
    return w;
  endfunction

  // Offers one event word and returns at the edge where it is accepted. Valid stays
  // high afterwards; it is only lowered when an idle gap or a drain follows, so it is
  // never lowered and raised again in the same time step.
  task automatic send_word(input in_t w);
    if (!steady && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 22);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_event(w);
  endtask

  // Stops offering words and waits until every awaited word has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk_i);
  endtask

  // One register transfer: a setup cycle, then the access cycle until pready. Read
  // data are taken at the completing edge. The select is left high so that another
  // transfer may follow at once; the caller lowers it at the end.
  task automatic reg_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] data,
                            output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
  endtask

  // Changes the default timeout once the block is idle, then reads it back.
  task automatic set_default_timeout(input logic [TMO_W-1:0] value);
    logic [PDATA_W-1:0] rd;
    drain_results();
    reg_access(1'b1, DEFAULT_TIMEOUT_ADDR, PDATA_W'(value), rd);
    sb.default_tmo = value;
    reg_access(1'b0, DEFAULT_TIMEOUT_ADDR, '0, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.check_register(rd);
  endtask

  // Random traffic. Most events name one of sixteen pool nodes, so the table fills
  // slowly and the nodes cycle through boot-up, heartbeats and expiry; the rest name
  // any node (these fill the table and then draw table-full answers) or are noise.
  task automatic run_random_phase(input int count);
    in_t         w;
    int unsigned roll;
    logic [95:0] noise;
    for (int n = 0; n < count; n++) begin
      roll     = $urandom_range(0, 99);
      clock_ms = clock_ms + 32'($urandom_range(0, 250));
      w.node_id = ($urandom_range(0, 99) < 85) ? node_pool[$urandom_range(0, TABLE_DEPTH - 1)]
                                               : 7'($urandom_range(0, 127));
      if ($urandom_range(0, 99) < 80) begin
        case ($urandom_range(0, 2))
          0:       w.state_byte = HB_PREOP;
          1:       w.state_byte = HB_OPER;
          default: w.state_byte = HB_STOPPED;
        endcase
      end else begin
        w.state_byte = 8'($urandom_range(0, 255));
      end
      w.caps       = 8'($urandom_range(0, 255));
      w.timeout_ms = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 4000))
                                                  : 16'($urandom_range(0, 65535));
      w.now_ms     = ($urandom_range(0, 99) < 95) ? clock_ms : $urandom;
      if (roll < 35)      w.cmd = CMD_HEARTBEAT;
      else if (roll < 55) w.cmd = CMD_TICK;
      else if (roll < 67) w.cmd = CMD_BOOTUP;
      else if (roll < 79) w.cmd = CMD_REGISTER;
      else if (roll < 89) w.cmd = CMD_CAPS;
      else if (roll < 92) w.cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      else begin
        noise = {$urandom, $urandom, $urandom};
        w     = noise[$bits(in_t)-1:0];
      end
      send_word(w);
    end
  endtask

  // Result side: accepts words, checks them, and drops ready at random. Once, after
  // a few dozen words, it holds off for a long stretch so that the block backs up
  // and stalls its input while the sender keeps offering.
  initial begin
    int unsigned seen_words;
    bit          held;
    seen_words = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready) begin
        sb.check_result(out_data_o);
        seen_words++;
      end
      if (!held && seen_words >= 60) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= 22);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [PDATA_W-1:0] rd;
    bit                 taken [128];
    int unsigned        pick;

    // The pool holds the nodes of the directed part plus thirteen others, all distinct.
    foreach (taken[i]) taken[i] = 1'b0;
    node_pool[0] = 7'h00;
    node_pool[1] = 7'h7F;
    node_pool[2] = 7'h2A;
    foreach (node_pool[i]) begin
      if (i < 3) begin
        taken[node_pool[i]] = 1'b1;
      end else begin
        do pick = $urandom_range(0, 127); while (taken[pick]);
        taken[pick]  = 1'b1;
        node_pool[i] = 7'(pick);
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The register should come out of reset at its documented default.
    reg_access(1'b0, DEFAULT_TIMEOUT_ADDR, '0, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.check_register(rd);

    // Directed part. Node 0 gets a zero timeout, node 7F keeps the default.
    send_word(event_word(CMD_REGISTER, 7'h00, 8'h00, 8'h00, 16'h0000, 32'd100));
    send_word(event_word(CMD_CAPS, 7'h7F, 8'hFF, 8'hFF, 16'hFFFF, 32'd100));
    // A boot-up from an offline node gives a notice and a start request; a second
    // boot-up while online gives only the start request.
    send_word(event_word(CMD_BOOTUP, 7'h00, 8'h00, 8'h00, 16'h0000, 32'd110));
    send_word(event_word(CMD_BOOTUP, 7'h00, 8'h00, 8'h00, 16'h0000, 32'd110));
    // State change gives a notice, an unchanged heartbeat gives a done word.
    send_word(event_word(CMD_HEARTBEAT, 7'h00, HB_OPER, 8'h00, 16'h0000, 32'd120));
    send_word(event_word(CMD_HEARTBEAT, 7'h00, HB_OPER, 8'h00, 16'h0000, 32'd120));
    // Heartbeats from an offline node with the stopped and pre-operational bytes, then unknown bytes.
    send_word(event_word(CMD_HEARTBEAT, 7'h7F, HB_STOPPED, 8'h00, 16'h0000, 32'd130));
    send_word(event_word(CMD_HEARTBEAT, 7'h7F, HB_PREOP, 8'h00, 16'h0000, 32'd130));
    send_word(event_word(CMD_HEARTBEAT, 7'h7F, 8'hFF, 8'h00, 16'h0000, 32'd130));
    send_word(event_word(CMD_HEARTBEAT, 7'h7F, 8'h00, 8'h00, 16'h0000, 32'd130));
    // Ticks: node 0 expires at once, node 7F survives an elapsed time equal to its
    // timeout and expires one millisecond later. The node field is ignored.
    send_word(event_word(CMD_TICK, 7'h55, 8'h00, 8'h00, 16'h0000, 32'd131));
    send_word(event_word(CMD_TICK, 7'h55, 8'h00, 8'h00, 16'h0000, 32'd3130));
    send_word(event_word(CMD_TICK, 7'h55, 8'h00, 8'h00, 16'h0000, 32'd3131));
    // Capability report on an offline node reports its offline state.
    send_word(event_word(CMD_CAPS, 7'h00, 8'h00, 8'h00, 16'h0000, 32'd3200));
    // Unused command codes.
    for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++) begin
      send_word(event_word(3'(c), 7'h7F, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF));
    end
    // Largest timeout across a wrap of the millisecond clock: equal elapsed time
    // keeps the node, one more millisecond drops it.
    send_word(event_word(CMD_REGISTER, 7'h2A, 8'h00, 8'h00, 16'hFFFF, 32'hFFFF_FF00));
    send_word(event_word(CMD_BOOTUP, 7'h2A, 8'h00, 8'h00, 16'h0000, 32'hFFFF_FF00));
    send_word(event_word(CMD_TICK, 7'h00, 8'h00, 8'h00, 16'h0000, 32'h0000_FE00));
    send_word(event_word(CMD_TICK, 7'h00, 8'h00, 8'h00, 16'h0000, 32'h0000_FEFF));
    send_word(event_word(CMD_TICK, 7'h00, 8'h00, 8'h00, 16'h0000, 32'h0000_FF00));
    send_word(event_word(CMD_HEARTBEAT, 7'h2A, HB_OPER, 8'h00, 16'h0000, 32'hFFFF_FFFF));

    // Random phases, each under a different default timeout. The second one runs
    // without idle cycles on either side, the third starts the clock near its wrap.
    clock_ms = 32'h0002_0000;
    run_random_phase(115);
    set_default_timeout('0);
    steady = 1'b1;
    run_random_phase(115);
    steady = 1'b0;
    set_default_timeout('1);
    clock_ms = 32'hFFFF_8000;
    run_random_phase(115);
    set_default_timeout(16'($urandom_range(1, 65534)));
    run_random_phase(115);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
